@@ rtl/diff_drive_odometry_assert.svh @@
// Assertion macros used by the odometry top level.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef DIFF_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define DDO_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define DDO_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ddo_pkg.sv @@
// Odometry package: widths, fixed-point constants, sequencer states, arctangent table.
// No dependencies.
package ddo_pkg;

  localparam int CORDIC_STEPS_DEF = 24;

  // configuration port
  localparam int CFG_W  = 32;
  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] REG_MPT = 1'b0;
  localparam logic [CFG_AW-1:0] REG_RPT = 1'b1;
  localparam logic [CFG_W-1:0]  MPT_RESET = 32'd8095821;
  localparam logic [CFG_W-1:0]  RPT_RESET = 32'd16191642;

  // frame markers
  localparam logic [7:0] START_MARK = 8'h02;
  localparam logic [7:0] END_MARK   = 8'h03;

  // shared multiplier
  localparam int MUL_AW = 24;
  localparam int MUL_BW = 32;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam logic [MUL_BW-1:0] GAIN_Q32 = 32'd2608131496;

  // rotator
  localparam int GUARD   = 8;
  localparam int XW      = 52;
  localparam int DW      = XW - GUARD;
  localparam int ZW      = 33;
  localparam int ATAN_IW = 5;
  localparam logic signed [ZW-1:0] PI_Z      = 33'sd1686629713;
  localparam logic signed [ZW-1:0] HALF_PI_Z = 33'sd843314857;

  // heading reduction
  localparam int WRAP_IW    = 47;
  localparam int WRAP_VW    = 48;
  localparam int WRAP_STEPS = 17;
  localparam int WRAP_CW    = 5;
  localparam logic [WRAP_VW-1:0] TWO_PI_W = 48'd3373259426;

  localparam int POS_W = 48;
  localparam int HDG_W = 32;
  localparam int TICK_W = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_DIST,
    S_MUL_HI,
    S_MUL_LO,
    S_MUL_DTH,
    S_WRAP_GO,
    S_WAIT,
    S_POS
  } ddo_state_t;

  typedef struct packed {
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
  } rot_res_t;

  // arctan(2^-i) in Q3.29
  function automatic logic [31:0] atan_q29(input logic [ATAN_IW-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd421657428;
      5'd1:    v = 32'd248918915;
      5'd2:    v = 32'd131521918;
      5'd3:    v = 32'd66762579;
      5'd4:    v = 32'd33510843;
      5'd5:    v = 32'd16771758;
      5'd6:    v = 32'd8387925;
      5'd7:    v = 32'd4194219;
      5'd8:    v = 32'd2097141;
      5'd9:    v = 32'd1048575;
      5'd10:   v = 32'd524288;
      5'd11:   v = 32'd262144;
      5'd12:   v = 32'd131072;
      5'd13:   v = 32'd65536;
      5'd14:   v = 32'd32768;
      5'd15:   v = 32'd16384;
      5'd16:   v = 32'd8192;
      5'd17:   v = 32'd4096;
      5'd18:   v = 32'd2048;
      5'd19:   v = 32'd1024;
      5'd20:   v = 32'd512;
      5'd21:   v = 32'd256;
      5'd22:   v = 32'd128;
      5'd23:   v = 32'd64;
      5'd24:   v = 32'd32;
      5'd25:   v = 32'd16;
      5'd26:   v = 32'd8;
      5'd27:   v = 32'd4;
      5'd28:   v = 32'd2;
      5'd29:   v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/ddo_mul.sv @@
// Shared unsigned multiplier with registered product.
// Depends on ddo_pkg.
module ddo_mul (
  input  logic                        clk,
  input  logic [ddo_pkg::MUL_AW-1:0]  a_i,
  input  logic [ddo_pkg::MUL_BW-1:0]  b_i,
  output logic [ddo_pkg::MUL_PW-1:0]  p_o
);
  import ddo_pkg::*;

  logic [MUL_PW-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= MUL_PW'(a_i) * MUL_PW'(b_i);
  end

  assign p_o = p_r;

endmodule

@@ rtl/ddo_cordic.sv @@
// Iterative CORDIC rotator: one shift-add step per cycle on a single x/y/z datapath.
// Depends on ddo_pkg (widths, arctangent table, result struct).
module ddo_cordic #(
  parameter int STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  logic signed [ddo_pkg::XW-1:0]    x0_i,
  input  logic signed [ddo_pkg::HDG_W-1:0] z0_i,
  output logic                        busy_o,
  output ddo_pkg::rot_res_t           res_o
);
  import ddo_pkg::*;

  localparam logic [ATAN_IW-1:0] LAST = ATAN_IW'(STEPS - 1);

  logic signed [XW-1:0] x_r, y_r, xs, ys, xf, yf;
  logic signed [ZW-1:0] z_r, z0e, zst, at;
  logic                 flip_r, flip_st;
  logic [ATAN_IW-1:0]   cnt_r;
  logic                 busy_r;

  // fold the angle into a half turn; the vector is negated at the end
  always_comb begin
    z0e = ZW'(z0_i);
    if (z0e > HALF_PI_Z) begin
      zst     = z0e - PI_Z;
      flip_st = 1'b1;
    end else if (z0e < -HALF_PI_Z) begin
      zst     = z0e + PI_Z;
      flip_st = 1'b1;
    end else begin
      zst     = z0e;
      flip_st = 1'b0;
    end
  end

  assign xs = x_r >>> cnt_r;
  assign ys = y_r >>> cnt_r;
  assign at = $signed({1'b0, atan_q29(cnt_r)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r == LAST) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      x_r    <= x0_i;
      y_r    <= '0;
      z_r    <= zst;
      flip_r <= flip_st;
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

  assign xf = flip_r ? -x_r : x_r;
  assign yf = flip_r ? -y_r : y_r;

  assign busy_o   = busy_r;
  assign res_o.dx = xf[XW-1:GUARD];
  assign res_o.dy = yf[XW-1:GUARD];

endmodule

@@ rtl/ddo_wrap.sv @@
// Heading reduction into [-pi, pi): restoring compare-subtract of 2*pi, one multiple a cycle.
// Depends on ddo_pkg.
module ddo_wrap (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start_i,
  input  logic signed [ddo_pkg::WRAP_IW-1:0] v_i,
  output logic                               busy_o,
  output logic signed [ddo_pkg::HDG_W-1:0]   heading_o
);
  import ddo_pkg::*;

  localparam logic [WRAP_VW-1:0] DIV_TOP = TWO_PI_W << (WRAP_STEPS - 1);
  localparam logic [WRAP_VW-1:0] BIAS    = TWO_PI_W << (WRAP_STEPS - 2);
  localparam logic [WRAP_CW-1:0] CNT_TOP = WRAP_CW'(WRAP_STEPS - 1);

  logic signed [WRAP_VW-1:0] v_ext;
  logic [WRAP_VW-1:0]        v0, v_r, d_r;
  logic [WRAP_CW-1:0]        cnt_r;
  logic                      busy_r;

  // a negative sum is lifted by a multiple of 2*pi first
  assign v_ext = WRAP_VW'(v_i);
  assign v0    = v_ext + (v_i[WRAP_IW-1] ? BIAS : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_TOP;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      v_r <= v0;
      d_r <= DIV_TOP;
    end else if (busy_r) begin
      if (v_r >= d_r) begin
        v_r <= v_r - d_r;
      end
      d_r <= d_r >> 1;
    end
  end

  assign busy_o    = busy_r;
  assign heading_o = HDG_W'($signed({1'b0, v_r[HDG_W-1:0]}) - PI_Z);

endmodule

@@ rtl/diff_drive_odometry.sv @@
// Channel | Width | Contents (low bits first)
// in_     | 48    | start_marker[7:0], end_marker[15:8], right_ticks[31:16], left_ticks[47:32]
// out_    | 160   | pose_x, pose_y, pose_heading, right_echo, left_echo
// cfg_    | 32    | index 0 metres_per_tick, index 1 radians_per_tick
//
// The time from accept to result is set by the rotator, at one shift-add step a cycle; the 17-step
// heading reduction runs alongside and only sets it when CORDIC_STEPS is below 18 steps.
// The next frame can be taken in the cycle after the result loads.
// A frame with bad markers is taken and dropped, gives no result and leaves the sequencer idle.
// Reset is synchronous; pose clears to zero and configuration registers take their defaults.
// The output register holds a result until taken; the next frame may be accepted meanwhile,
// and its pose update waits while the output register is still full.
// Top level: sequencer, multiplier operand muxing, pose registers. Needs ddo_pkg,
// ddo_mul, ddo_cordic, ddo_wrap and the assertion macro header.
`include "diff_drive_odometry_assert.svh"

module diff_drive_odometry #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [47:0]                 in_tdata,   // start_marker, end_marker, right, left
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [159:0]                out_tdata,  // pose_x, pose_y, heading, right, left
  input  logic                        cfg_we,
  input  logic [ddo_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [ddo_pkg::CFG_W-1:0]   cfg_wdata
);
  import ddo_pkg::*;

  ddo_state_t state_r, state_nxt;

  logic [CFG_W-1:0]  mpt_r, rpt_r;
  logic [TICK_W-1:0] r_r, l_r, mag;
  logic [TICK_W:0]   sum;
  logic              in_fire, frame_ok, out_free, lr_neg;

  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] mul_p, acc_r;
  logic [15:0]       lo_r;
  logic [MUL_PW:0]   p_sum;
  logic signed [XW-1:0] x0;

  logic [44:0]               dth;
  logic signed [WRAP_IW-1:0] dth_s, wrap_v;

  logic cor_start, wrap_start, lo_ld, acc_ld, pos_ld;
  logic cor_busy, wrap_busy;
  rot_res_t rot_res;
  logic signed [HDG_W-1:0] hdg_new;

  logic signed [POS_W-1:0] pos_x_r, pos_y_r, pos_x_nxt, pos_y_nxt;
  logic signed [POS_W:0]   sx, sy;
  logic signed [HDG_W-1:0] heading_r;

  logic         out_tvalid_r;
  logic [159:0] out_tdata_r;

  assign in_fire  = in_tvalid && in_tready;
  assign frame_ok = (in_tdata[7:0] == START_MARK) && (in_tdata[15:8] == END_MARK);
  assign out_free = !out_tvalid_r || out_tready;

  assign sum    = (TICK_W+1)'(r_r) + (TICK_W+1)'(l_r);
  assign lr_neg = l_r > r_r;
  assign mag    = lr_neg ? (l_r - r_r) : (r_r - l_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_fire && frame_ok) state_nxt = S_MUL_DIST;
      S_MUL_DIST: state_nxt = S_MUL_HI;
      S_MUL_HI:   state_nxt = S_MUL_LO;
      S_MUL_LO:   state_nxt = S_MUL_DTH;
      S_MUL_DTH:  state_nxt = S_WRAP_GO;
      S_WRAP_GO:  state_nxt = S_WAIT;
      S_WAIT:     if (!cor_busy && !wrap_busy) state_nxt = S_POS;
      S_POS:      if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    lo_ld      = 1'b0;
    acc_ld     = 1'b0;
    cor_start  = 1'b0;
    wrap_start = 1'b0;
    pos_ld     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
      end
      S_MUL_DIST: begin
        mul_a = MUL_AW'(sum);
        mul_b = mpt_r;
      end
      S_MUL_HI: begin
        // product is distance << 9; take its high part against the gain
        mul_a = mul_p[48:25];
        mul_b = GAIN_Q32;
        lo_ld = 1'b1;
      end
      S_MUL_LO: begin
        mul_a  = MUL_AW'(lo_r);
        mul_b  = GAIN_Q32;
        acc_ld = 1'b1;
      end
      S_MUL_DTH: begin
        mul_a     = MUL_AW'(mag);
        mul_b     = rpt_r;
        cor_start = 1'b1;
      end
      S_WRAP_GO: begin
        wrap_start = 1'b1;
      end
      S_WAIT: begin
      end
      S_POS: begin
        pos_ld = out_free;
      end
      default: begin
      end
    endcase
  end

  ddo_mul u_mul (
    .clk (clk),
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  // gained distance with guard bits
  assign p_sum = (MUL_PW+1)'(acc_r) + (MUL_PW+1)'(mul_p[MUL_PW-1:16]);
  assign x0    = $signed(XW'(p_sum >> GUARD));

  ddo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cor_start),
    .x0_i    (x0),
    .z0_i    (heading_r),
    .busy_o  (cor_busy),
    .res_o   (rot_res)
  );

  // heading change, truncated toward zero
  assign dth    = mul_p[47:3];
  assign dth_s  = lr_neg ? -$signed({2'b00, dth}) : $signed({2'b00, dth});
  assign wrap_v = WRAP_IW'(heading_r) + WRAP_IW'(PI_Z) + dth_s;

  ddo_wrap u_wrap (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (wrap_start),
    .v_i       (wrap_v),
    .busy_o    (wrap_busy),
    .heading_o (hdg_new)
  );

  // saturating position update
  assign sx = (POS_W+1)'(pos_x_r) + (POS_W+1)'(rot_res.dx);
  assign sy = (POS_W+1)'(pos_y_r) + (POS_W+1)'(rot_res.dy);

  always_comb begin
    if (sx[POS_W] != sx[POS_W-1]) begin
      pos_x_nxt = sx[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      pos_x_nxt = sx[POS_W-1:0];
    end
    if (sy[POS_W] != sy[POS_W-1]) begin
      pos_y_nxt = sy[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      pos_y_nxt = sy[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mpt_r        <= MPT_RESET;
      rpt_r        <= RPT_RESET;
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      heading_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_MPT: mpt_r <= cfg_wdata;
          REG_RPT: rpt_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (pos_ld) begin
        pos_x_r      <= pos_x_nxt;
        pos_y_r      <= pos_y_nxt;
        heading_r    <= hdg_new;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      r_r <= in_tdata[31:16];
      l_r <= in_tdata[47:32];
    end
    if (lo_ld) begin
      lo_r <= mul_p[24:9];
    end
    if (acc_ld) begin
      acc_r <= mul_p;
    end
    if (pos_ld) begin
      out_tdata_r <= {l_r, r_r, hdg_new, pos_y_nxt, pos_x_nxt};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `DDO_ASSERT_IMPL(a_idle_units_quiet, in_tready, !cor_busy && !wrap_busy, "unit busy while idle")
  `DDO_ASSERT_IMPL(a_heading_range, 1'b1, (heading_r >= -PI_Z) && (heading_r < PI_Z), "heading out of range")
  `DDO_ASSERT_NEXT(a_result_loaded, pos_ld, out_tvalid_r, "pose update without result")
  `DDO_ASSERT_NEXT(a_good_frame_starts, in_fire && frame_ok, state_r == S_MUL_DIST, "good frame not started")

endmodule
